// ----- rtl/tjd_pkg.sv -----
// Joystick direction decoder package: shared widths, event, direction and register codes.
// Used by the channel interfaces, the top level and the port checker.
package tjd_pkg;

   localparam int RAD_BITS       = 11;
   localparam int HALF_BITS      = 10;
   localparam int OP_BITS        = 2;
   localparam int DIR_BITS       = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int MUL_STEPS      = 7;

   // touch event kinds
   localparam logic [OP_BITS-1:0] OP_BEGIN = 2'd0;
   localparam logic [OP_BITS-1:0] OP_MOVE  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_END   = 2'd2;

   // direction codes
   localparam logic [DIR_BITS-1:0] DIR_STAY       = 4'd0;
   localparam logic [DIR_BITS-1:0] DIR_RIGHT      = 4'd1;
   localparam logic [DIR_BITS-1:0] DIR_RIGHT_UP   = 4'd2;
   localparam logic [DIR_BITS-1:0] DIR_UP         = 4'd3;
   localparam logic [DIR_BITS-1:0] DIR_LEFT_UP    = 4'd4;
   localparam logic [DIR_BITS-1:0] DIR_LEFT       = 4'd5;
   localparam logic [DIR_BITS-1:0] DIR_LEFT_DOWN  = 4'd6;
   localparam logic [DIR_BITS-1:0] DIR_DOWN       = 4'd7;
   localparam logic [DIR_BITS-1:0] DIR_RIGHT_DOWN = 4'd8;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_HEIGHT = 3'd4;

   localparam logic [RAD_BITS-1:0]  RADIUS_RESET = 11'd64;
   localparam logic [HALF_BITS-1:0] HALF_RESET   = 10'd32;

   // products formed by the shared multiplier, in issue order
   localparam logic [2:0] MOP_AX2   = 3'd0;
   localparam logic [2:0] MOP_AY2   = 3'd1;
   localparam logic [2:0] MOP_SUM2  = 3'd2;
   localparam logic [2:0] MOP_DIFF2 = 3'd3;
   localparam logic [2:0] MOP_R2    = 3'd4;
   localparam logic [2:0] MOP_RAX   = 3'd5;
   localparam logic [2:0] MOP_RAY   = 3'd6;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EVAL = 7'b0000010,
      S_MUL  = 7'b0000100,
      S_ROOT = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_FIN  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

endpackage

// ----- rtl/tjd_if.sv -----
// Valid/ready channel interfaces of the joystick direction decoder.
// Depends on tjd_pkg for field widths.
interface tjd_req_if #(parameter int COORD_BITS = 12);
   logic                          valid;
   logic                          ready;
   logic [tjd_pkg::OP_BITS-1:0]   op;
   logic [COORD_BITS-1:0]         touch_x;
   logic [COORD_BITS-1:0]         touch_y;
   modport source (output valid, output op, output touch_x, output touch_y, input ready);
   modport sink (input valid, input op, input touch_x, input touch_y, output ready);
endinterface

interface tjd_rsp_if #(parameter int COORD_BITS = 12);
   logic                          valid;
   logic                          ready;
   logic [tjd_pkg::DIR_BITS-1:0]  direction;
   logic                          facing_left;
   logic [COORD_BITS-1:0]         knob_x;
   logic [COORD_BITS-1:0]         knob_y;
   logic                          tracking;
   modport source (output valid, output direction, output facing_left, output knob_x,
                   output knob_y, output tracking, input ready);
   modport sink (input valid, input direction, input facing_left, input knob_x,
                 input knob_y, input tracking, output ready);
endinterface

interface tjd_csr_if #(parameter int DATA_BITS = 12);
   logic                                valid;
   logic                                ready;
   logic [tjd_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [DATA_BITS-1:0]                data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tjd_mul.sv -----
// Shared unsigned multiplier with a registered product.
// Standalone; instantiated by the decoder top level.
module tjd_mul #(
   parameter int WIDTH = 13
) (
   input  logic                 clock,
   input  logic [WIDTH-1:0]     a,
   input  logic [WIDTH-1:0]     b,
   output logic [2*WIDTH-1:0]   prod_ff
);

   logic [2*WIDTH-1:0] prod_in;

   assign prod_in = (2*WIDTH)'(a) * (2*WIDTH)'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- rtl/touch_joystick_direction_decoder_top.sv -----
// Eight-way touch joystick direction decoder: top level, sequencer and datapath.
// Depends on tjd_pkg, the channel interfaces in tjd_if.sv and the multiplier tjd_mul.
//
// One request (touch begin, move or end) yields one response with the direction,
// facing flag, knob position and tracking flag after the event. The block works on
// one request at a time: req ready is high only while the sequencer is idle, and a
// finished response waits in its own output register, so the next request can be
// taken while the previous response is still stalled. A begin, an end, an unused
// event code or a move while not tracking is decoded in one state and then loaded
// into the response register. A move is decoded, then the single shared multiplier
// forms seven products (ax^2, ay^2, (ax+ay)^2, (ay-ax)^2, r^2, r*ax, r*ay)
// one per cycle, then the response is loaded. A move whose distance reaches the
// radius adds a digit-by-digit square root and a restoring division for each axis
// on one shared subtractor, then a saturating knob add. Each response load is
// followed by the idle state, in which the next request is taken; a response
// register that is still stalled holds the block before the load. Configuration
// writes are always taken (csr ready is tied high) and are meant to happen while
// the block is idle.
module touch_joystick_direction_decoder_top #(
   parameter int COORD_BITS = 12
) (
   input  logic          clock,
   input  logic          reset,
   tjd_req_if.sink       req_ch,
   tjd_rsp_if.source     rsp_ch,
   tjd_csr_if.sink       csr_ch
);

   localparam int W        = COORD_BITS;
   localparam int K        = W + 1;                  // root width
   localparam int R        = tjd_pkg::RAD_BITS;
   localparam int HB       = tjd_pkg::HALF_BITS;
   localparam int MW       = (K > R) ? K : R;        // multiplier operand width
   localparam int PW       = 2 * MW;
   localparam int D2W      = 2 * W + 1;              // squared distance
   localparam int SQW      = 2 * W + 2;              // (ax+ay)^2 and root radicand
   localparam int CW       = (D2W > 2 * R) ? D2W : 2 * R;
   localparam int NW       = R + W;                  // r*|d|
   localparam int RW       = W + 2;                  // partial remainder
   localparam int SUBW     = W + 4;                  // shared subtractor
   localparam int CMPW     = (W > HB) ? W : HB;
   localparam int EW       = ((W > R) ? W : R) + 2;  // signed knob sum
   localparam int ITER_MAX = (K > R) ? K : R;
   localparam int CNTW     = $clog2(ITER_MAX + 1);

   // configuration registers
   logic [W-1:0]  center_x_ff, center_y_ff;
   logic [R-1:0]  radius_ff;
   logic [HB-1:0] half_w_ff, half_h_ff;

   // sequencer and joystick state
   tjd_pkg::state_type state_ff, state_in;
   logic [CNTW-1:0]    cnt_ff, cnt_in;
   logic               armed_ff, armed_in;
   logic [tjd_pkg::DIR_BITS-1:0] dir_ff, dir_in;
   logic               facing_ff, facing_in;
   logic [W-1:0]       knob_x_ff, knob_x_in, knob_y_ff, knob_y_in;

   // request and datapath registers
   logic [tjd_pkg::OP_BITS-1:0] op_ff, op_in;
   logic [W-1:0]  tx_ff, tx_in, ty_ff, ty_in;
   logic [W-1:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic          negx_ff, negx_in, negy_ff, negy_in;
   logic [2*W-1:0] ax2_ff, ax2_in;
   logic [D2W-1:0] d2_ff, d2_in;
   logic          horiz_ff, horiz_in, vert_ff, vert_in, clamp_ff, clamp_in;
   logic [NW-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [SQW-1:0] rad_ff, rad_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [K-1:0]  root_ff, root_in;
   logic [R-1:0]  dq_ff, dq_in, qx_ff, qx_in;
   logic          axis_ff, axis_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [tjd_pkg::DIR_BITS-1:0] rsp_dir_ff, rsp_dir_in;
   logic          rsp_facing_ff, rsp_facing_in, rsp_track_ff, rsp_track_in;
   logic [W-1:0]  rsp_kx_ff, rsp_kx_in, rsp_ky_ff, rsp_ky_in;

   // combinational helpers
   logic          req_fire;
   logic [K-1:0]  dx_c, dy_c, adx_c, ady_c;
   logic          ay_gt_ax, pos_x, pos_y, zero_off;
   logic [2:0]    cap_op;
   logic [MW-1:0] mul_a, mul_b;
   logic [PW-1:0] prod_ff;
   logic [SUBW-1:0] sub_a, sub_b;
   logic [SUBW:0] sub_diff;
   logic          sub_ok;
   logic [R-1:0]  dq_next;
   logic [EW-1:0] ext_x, ext_y;
   logic [W-1:0]  sat_x, sat_y;

   // ---------------------------------------------------------------- ports
   assign req_ch.ready       = (state_ff == tjd_pkg::S_IDLE);
   assign req_fire           = req_ch.valid && req_ch.ready;
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.direction   = rsp_dir_ff;
   assign rsp_ch.facing_left = rsp_facing_ff;
   assign rsp_ch.knob_x      = rsp_kx_ff;
   assign rsp_ch.knob_y      = rsp_ky_ff;
   assign rsp_ch.tracking    = rsp_track_ff;

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= tjd_pkg::RADIUS_RESET;
         half_w_ff   <= tjd_pkg::HALF_RESET;
         half_h_ff   <= tjd_pkg::HALF_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            tjd_pkg::CSR_CENTER_X:    center_x_ff <= csr_ch.data[W-1:0];
            tjd_pkg::CSR_CENTER_Y:    center_y_ff <= csr_ch.data[W-1:0];
            tjd_pkg::CSR_RADIUS:      radius_ff   <= csr_ch.data[R-1:0];
            tjd_pkg::CSR_HALF_WIDTH:  half_w_ff   <= csr_ch.data[HB-1:0];
            tjd_pkg::CSR_HALF_HEIGHT: half_h_ff   <= csr_ch.data[HB-1:0];
            default: ;   // writes beyond the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- offsets at accept
   // Offset from the centre in one extra bit; magnitude always fits COORD_BITS.
   assign dx_c  = {1'b0, req_ch.touch_x} - {1'b0, center_x_ff};
   assign dy_c  = {1'b0, req_ch.touch_y} - {1'b0, center_y_ff};
   assign adx_c = dx_c[W] ? (K'(0) - dx_c) : dx_c;
   assign ady_c = dy_c[W] ? (K'(0) - dy_c) : dy_c;

   assign ay_gt_ax = ay_ff > ax_ff;
   assign pos_x    = !negx_ff && (ax_ff != '0);
   assign pos_y    = !negy_ff && (ay_ff != '0);
   assign zero_off = (ax_ff == '0) && (ay_ff == '0);

   // ---------------------------------------------------------------- shared multiplier
   // Issue product number cnt; its result is captured from the registered product in the next cycle.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cnt_ff[2:0])
         tjd_pkg::MOP_AX2: begin
            mul_a = MW'(ax_ff);
            mul_b = MW'(ax_ff);
         end
         tjd_pkg::MOP_AY2: begin
            mul_a = MW'(ay_ff);
            mul_b = MW'(ay_ff);
         end
         tjd_pkg::MOP_SUM2: begin
            mul_a = MW'(K'(ax_ff) + K'(ay_ff));
            mul_b = MW'(K'(ax_ff) + K'(ay_ff));
         end
         tjd_pkg::MOP_DIFF2: begin
            mul_a = ay_gt_ax ? MW'(ay_ff - ax_ff) : '0;
            mul_b = ay_gt_ax ? MW'(ay_ff - ax_ff) : '0;
         end
         tjd_pkg::MOP_R2: begin
            mul_a = MW'(radius_ff);
            mul_b = MW'(radius_ff);
         end
         tjd_pkg::MOP_RAX: begin
            mul_a = MW'(radius_ff);
            mul_b = MW'(ax_ff);
         end
         tjd_pkg::MOP_RAY: begin
            mul_a = MW'(radius_ff);
            mul_b = MW'(ay_ff);
         end
         default: ;
      endcase
   end

   tjd_mul #(.WIDTH(MW)) u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod_ff)
   );

   assign cap_op = cnt_ff[2:0] - 3'd1;

   // ---------------------------------------------------------------- shared subtractor
   // Square root: trial 4*root+1 against the remainder with the next radicand pair.
   // Division: divisor (the root) against the remainder with the next dividend bit.
   always_comb begin
      sub_a = '0;
      sub_b = '0;
      case (state_ff)
         tjd_pkg::S_ROOT: begin
            sub_a = {rem_ff, rad_ff[SQW-1 -: 2]};
            sub_b = SUBW'({root_ff, 2'b01});
         end
         tjd_pkg::S_DIV: begin
            sub_a = SUBW'({rem_ff, dq_ff[R-1]});
            sub_b = SUBW'(root_ff);
         end
         default: ;
      endcase
   end

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ok   = !sub_diff[SUBW];
   assign dq_next  = {dq_ff[R-2:0], sub_ok};

   // ---------------------------------------------------------------- knob on the circle
   // Centre plus or minus the scaled offset, saturated to the coordinate range.
   assign ext_x = negx_ff ? (EW'(center_x_ff) - EW'(qx_ff)) : (EW'(center_x_ff) + EW'(qx_ff));
   assign ext_y = negy_ff ? (EW'(center_y_ff) - EW'(dq_ff)) : (EW'(center_y_ff) + EW'(dq_ff));
   assign sat_x = ext_x[EW-1] ? '0 : ((ext_x > EW'({W{1'b1}})) ? {W{1'b1}} : ext_x[W-1:0]);
   assign sat_y = ext_y[EW-1] ? '0 : ((ext_y > EW'({W{1'b1}})) ? {W{1'b1}} : ext_y[W-1:0]);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      armed_in      = armed_ff;
      dir_in        = dir_ff;
      facing_in     = facing_ff;
      knob_x_in     = knob_x_ff;
      knob_y_in     = knob_y_ff;
      op_in         = op_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      negx_in       = negx_ff;
      negy_in       = negy_ff;
      ax2_in        = ax2_ff;
      d2_in         = d2_ff;
      horiz_in      = horiz_ff;
      vert_in       = vert_ff;
      clamp_in      = clamp_ff;
      nx_in         = nx_ff;
      ny_in         = ny_ff;
      rad_in        = rad_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      dq_in         = dq_ff;
      qx_in         = qx_ff;
      axis_in       = axis_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_dir_in    = rsp_dir_ff;
      rsp_facing_in = rsp_facing_ff;
      rsp_track_in  = rsp_track_ff;
      rsp_kx_in     = rsp_kx_ff;
      rsp_ky_in     = rsp_ky_ff;

      case (state_ff)
         tjd_pkg::S_IDLE: begin
            // take the request and its offsets from the centre
            if (req_fire) begin
               op_in    = req_ch.op;
               tx_in    = req_ch.touch_x;
               ty_in    = req_ch.touch_y;
               ax_in    = adx_c[W-1:0];
               ay_in    = ady_c[W-1:0];
               negx_in  = dx_c[W];
               negy_in  = dy_c[W];
               state_in = tjd_pkg::S_EVAL;
            end
         end

         tjd_pkg::S_EVAL: begin
            state_in = tjd_pkg::S_DONE;
            case (op_ff)
               tjd_pkg::OP_BEGIN: begin
                  // inclusive hit box; a miss leaves tracking as it was
                  if ((CMPW'(ax_ff) <= CMPW'(half_w_ff)) && (CMPW'(ay_ff) <= CMPW'(half_h_ff)))
                     armed_in = 1'b1;
               end
               tjd_pkg::OP_MOVE: begin
                  if (armed_ff) begin
                     cnt_in   = '0;
                     state_in = tjd_pkg::S_MUL;
                  end
               end
               tjd_pkg::OP_END: begin
                  if (armed_ff) begin
                     knob_x_in = center_x_ff;
                     knob_y_in = center_y_ff;
                     dir_in    = tjd_pkg::DIR_STAY;
                     armed_in  = 1'b0;
                  end
               end
               default: ;   // unused event code: report the state unchanged
            endcase
         end

         tjd_pkg::S_MUL: begin
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff != '0) begin
               case (cap_op)
                  tjd_pkg::MOP_AX2:   ax2_in = prod_ff[2*W-1:0];
                  tjd_pkg::MOP_AY2:   d2_in = D2W'(ax2_ff) + D2W'(prod_ff[2*W-1:0]);
                  // angle below pi/8 when (ax+ay)^2 < 2*ax^2
                  tjd_pkg::MOP_SUM2:  horiz_in = prod_ff[SQW-1:0] < SQW'({ax2_ff, 1'b0});
                  // angle above 3pi/8 when ay > ax and (ay-ax)^2 > 2*ax^2
                  tjd_pkg::MOP_DIFF2: vert_in = ay_gt_ax &&
                                                (D2W'(prod_ff[2*W-1:0]) > {ax2_ff, 1'b0});
                  tjd_pkg::MOP_R2:    clamp_in = CW'(d2_ff) >= CW'(prod_ff[2*R-1:0]);
                  tjd_pkg::MOP_RAX:   nx_in = prod_ff[NW-1:0];
                  tjd_pkg::MOP_RAY:   ny_in = prod_ff[NW-1:0];
                  default: ;
               endcase
            end
            if (cnt_ff == CNTW'(tjd_pkg::MUL_STEPS)) begin
               if (zero_off) begin
                  // touch on the centre: knob home, direction and facing held
                  knob_x_in = center_x_ff;
                  knob_y_in = center_y_ff;
                  state_in  = tjd_pkg::S_DONE;
               end else begin
                  if (horiz_ff) begin
                     dir_in    = pos_x ? tjd_pkg::DIR_RIGHT : tjd_pkg::DIR_LEFT;
                     facing_in = !pos_x;
                  end else if (vert_ff) begin
                     dir_in    = pos_y ? tjd_pkg::DIR_UP : tjd_pkg::DIR_DOWN;
                  end else if (pos_y) begin
                     dir_in    = pos_x ? tjd_pkg::DIR_RIGHT_UP : tjd_pkg::DIR_LEFT_UP;
                     facing_in = !pos_x;
                  end else begin
                     dir_in    = pos_x ? tjd_pkg::DIR_RIGHT_DOWN : tjd_pkg::DIR_LEFT_DOWN;
                     facing_in = !pos_x;
                  end
                  if (clamp_ff) begin
                     rad_in   = SQW'(d2_ff);
                     rem_in   = '0;
                     root_in  = '0;
                     cnt_in   = '0;
                     state_in = tjd_pkg::S_ROOT;
                  end else begin
                     knob_x_in = tx_ff;
                     knob_y_in = ty_ff;
                     state_in  = tjd_pkg::S_DONE;
                  end
               end
            end
         end

         tjd_pkg::S_ROOT: begin
            // one root bit per cycle, radicand consumed two bits at a time
            rem_in  = sub_ok ? sub_diff[RW-1:0] : sub_a[RW-1:0];
            root_in = {root_ff[K-2:0], sub_ok};
            rad_in  = {rad_ff[SQW-3:0], 2'b00};
            cnt_in  = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(K - 1)) begin
               // quotient fits the radius width, so start with the high part loaded
               rem_in   = RW'(nx_ff[NW-1:R]);
               dq_in    = nx_ff[R-1:0];
               axis_in  = 1'b0;
               cnt_in   = '0;
               state_in = tjd_pkg::S_DIV;
            end
         end

         tjd_pkg::S_DIV: begin
            // one quotient bit per cycle; dividend bits shift out, quotient bits in
            rem_in = sub_ok ? sub_diff[RW-1:0] : sub_a[RW-1:0];
            dq_in  = dq_next;
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(R - 1)) begin
               if (!axis_ff) begin
                  qx_in   = dq_next;
                  rem_in  = RW'(ny_ff[NW-1:R]);
                  dq_in   = ny_ff[R-1:0];
                  axis_in = 1'b1;
                  cnt_in  = '0;
               end else begin
                  state_in = tjd_pkg::S_FIN;
               end
            end
         end

         tjd_pkg::S_FIN: begin
            knob_x_in = sat_x;
            knob_y_in = sat_y;
            state_in  = tjd_pkg::S_DONE;
         end

         tjd_pkg::S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_dir_in    = dir_ff;
               rsp_facing_in = facing_ff;
               rsp_kx_in     = knob_x_ff;
               rsp_ky_in     = knob_y_ff;
               rsp_track_in  = armed_ff;
               state_in      = tjd_pkg::S_IDLE;
            end
         end

         default: state_in = tjd_pkg::S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tjd_pkg::S_IDLE;
         armed_ff     <= 1'b0;
         dir_ff       <= tjd_pkg::DIR_STAY;
         facing_ff    <= 1'b0;
         knob_x_ff    <= '0;
         knob_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         dir_ff       <= dir_in;
         facing_ff    <= facing_in;
         knob_x_ff    <= knob_x_in;
         knob_y_ff    <= knob_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and response payload
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      op_ff         <= op_in;
      tx_ff         <= tx_in;
      ty_ff         <= ty_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      negx_ff       <= negx_in;
      negy_ff       <= negy_in;
      ax2_ff        <= ax2_in;
      d2_ff         <= d2_in;
      horiz_ff      <= horiz_in;
      vert_ff       <= vert_in;
      clamp_ff      <= clamp_in;
      nx_ff         <= nx_in;
      ny_ff         <= ny_in;
      rad_ff        <= rad_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      dq_ff         <= dq_in;
      qx_ff         <= qx_in;
      axis_ff       <= axis_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_facing_ff <= rsp_facing_in;
      rsp_track_ff  <= rsp_track_in;
      rsp_kx_ff     <= rsp_kx_in;
      rsp_ky_ff     <= rsp_ky_in;
   end

endmodule

// ----- rtl/tjd_checker.sv -----
// Port checker for the joystick direction decoder, with its bind to the top level.
// Depends on tjd_pkg; sees the top level's channel signals only.
module tjd_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tjd_pkg::DIR_BITS-1:0]  rsp_direction,
   input logic                          rsp_facing_left,
   input logic [COORD_BITS-1:0]         rsp_knob_x,
   input logic [COORD_BITS-1:0]         rsp_knob_y,
   input logic                          rsp_tracking
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_direction) &&
      $stable(rsp_facing_left) && $stable(rsp_knob_x) && $stable(rsp_knob_y) &&
      $stable(rsp_tracking))
      else $error("response changed while stalled");

   // one request at a time: the block drops ready right after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   // no response can be ready the cycle after a request is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared too early");

   // without an active touch the direction is always stay
   a_idle_stay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tracking |-> rsp_direction == tjd_pkg::DIR_STAY)
      else $error("direction set while not tracking");

endmodule

bind touch_joystick_direction_decoder_top tjd_checker #(.COORD_BITS(COORD_BITS)) u_tjd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_direction   (rsp_ch.direction),
   .rsp_facing_left (rsp_ch.facing_left),
   .rsp_knob_x      (rsp_ch.knob_x),
   .rsp_knob_y      (rsp_ch.knob_y),
   .rsp_tracking    (rsp_ch.tracking)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for the eight-way touch joystick direction decoder: directed and random touch
// gestures, a local predictor of direction, facing, knob and tracking, and a response checker.
// Depends on tjd_pkg, the channel interfaces in rtl/tjd_if.sv and the top level under test.
module tb_top;

   localparam int COORD_BITS    = 12;
   localparam int CSR_DATA_BITS = 12;
   localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
   localparam int RADIUS_MAX    = (1 << tjd_pkg::RAD_BITS) - 1;
   localparam int HALF_MAX      = (1 << tjd_pkg::HALF_BITS) - 1;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 60;
   localparam logic [COORD_BITS-1:0] SCREEN_MAX = {COORD_BITS{1'b1}};

   // the fourth event code has no meaning; the block must ignore it
   localparam logic [tjd_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [tjd_pkg::DIR_BITS-1:0] direction;
      logic                         facing_left;
      logic [COORD_BITS-1:0]        knob_x;
      logic [COORD_BITS-1:0]        knob_y;
      logic                         tracking;
   } joystick_report_type;

   logic clock;
   logic reset;

   tjd_req_if #(.COORD_BITS(COORD_BITS))   req_ch ();
   tjd_rsp_if #(.COORD_BITS(COORD_BITS))   rsp_ch ();
   tjd_csr_if #(.DATA_BITS(CSR_DATA_BITS)) csr_ch ();

   touch_joystick_direction_decoder_top #(.COORD_BITS(COORD_BITS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Register copies, kept in step with every accepted configuration write.
   logic [COORD_BITS-1:0]         cfg_center_x = '0;
   logic [COORD_BITS-1:0]         cfg_center_y = '0;
   logic [tjd_pkg::RAD_BITS-1:0]  cfg_radius   = tjd_pkg::RADIUS_RESET;
   logic [tjd_pkg::HALF_BITS-1:0] cfg_half_w   = tjd_pkg::HALF_RESET;
   logic [tjd_pkg::HALF_BITS-1:0] cfg_half_h   = tjd_pkg::HALF_RESET;

   // Joystick state as the block should hold it after each accepted request.
   logic                         st_armed       = 1'b0;
   logic [tjd_pkg::DIR_BITS-1:0] st_direction   = tjd_pkg::DIR_STAY;
   logic                         st_facing_left = 1'b0;
   logic [COORD_BITS-1:0]        st_knob_x      = '0;
   logic [COORD_BITS-1:0]        st_knob_y      = '0;

   joystick_report_type pending_reports[$];

   bit   idle_enable   = 1'b1;  // both sides draw random waits while set
   int   response_hold = 0;     // one-shot long stall for the response side
   int   error_count   = 0;
   int   requests_sent = 0;
   int   responses_checked = 0;
   int   clamped_moves = 0;
   int   settings_used = 0;
   int   cycle_count   = 0;
   logic [8:0] directions_seen = '0;

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop: covers a hung handshake anywhere in the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_reports.size());
         $display("touch_joystick_direction_decoder_top test failed");
         $finish;
      end
   end

   function automatic logic [COORD_BITS-1:0] saturate_coord(input longint v);
      if (v < 0) return '0;
      if (v > COORD_MAX) return SCREEN_MAX;
      return v[COORD_BITS-1:0];
   endfunction

   // Random coordinate within +/- span of a point, saturated to the screen.
   function automatic logic [COORD_BITS-1:0] coord_near(input int center, input int span);
      return saturate_coord(longint'(center) + longint'($urandom_range(0, 2 * span))
                            - longint'(span));
   endfunction

   // Zero or the top value now and then, otherwise anywhere in range.
   function automatic int pick_extreme(input int top);
      case ($urandom_range(0, 4))
         0: return 0;
         1: return top;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   // Random screen coordinate.
   function automatic logic [COORD_BITS-1:0] any_coord();
      return COORD_BITS'($urandom_range(0, COORD_MAX));
   endfunction

   // Advance the joystick state by one accepted request and queue the report it yields.
   function automatic void predict_event(input logic [tjd_pkg::OP_BITS-1:0] op,
                                         input logic [COORD_BITS-1:0] tx,
                                         input logic [COORD_BITS-1:0] ty);
      longint dx, dy, ax, ay, d2, rad, root, ox, oy;
      logic horiz, vert;
      joystick_report_type report;
      dx  = longint'(tx) - longint'(cfg_center_x);
      dy  = longint'(ty) - longint'(cfg_center_y);
      ax  = (dx < 0) ? -dx : dx;
      ay  = (dy < 0) ? -dy : dy;
      d2  = ax * ax + ay * ay;
      rad = longint'(cfg_radius);
      case (op)
         tjd_pkg::OP_BEGIN: begin
            // hit box edges are inclusive; a miss leaves tracking as it was
            if (ax <= longint'(cfg_half_w) && ay <= longint'(cfg_half_h))
               st_armed = 1'b1;
         end
         tjd_pkg::OP_MOVE: begin
            if (st_armed && d2 == 0) begin
               // touch on the centre: knob home, direction and facing kept
               st_knob_x = cfg_center_x;
               st_knob_y = cfg_center_y;
            end else if (st_armed) begin
               if (d2 >= rad * rad) begin
                  // floor square root, bit by bit from the top
                  root = 0;
                  for (int b = 15; b >= 0; b--) begin
                     if ((root + (longint'(1) << b)) * (root + (longint'(1) << b)) <= d2)
                        root = root + (longint'(1) << b);
                  end
                  ox = (rad * ax) / root;
                  oy = (rad * ay) / root;
                  if (dx < 0) ox = -ox;
                  if (dy < 0) oy = -oy;
                  st_knob_x = saturate_coord(longint'(cfg_center_x) + ox);
                  st_knob_y = saturate_coord(longint'(cfg_center_y) + oy);
                  clamped_moves++;
               end else begin
                  st_knob_x = tx;
                  st_knob_y = ty;
               end
               horiz = ((ay + ax) * (ay + ax)) < (2 * ax * ax);
               vert  = (ay > ax) && (((ay - ax) * (ay - ax)) > (2 * ax * ax));
               if (horiz) begin
                  // a touch straight left of the centre counts as left
                  st_direction   = (dx > 0) ? tjd_pkg::DIR_RIGHT : tjd_pkg::DIR_LEFT;
                  st_facing_left = (dx <= 0);
               end else if (vert) begin
                  st_direction = (dy > 0) ? tjd_pkg::DIR_UP : tjd_pkg::DIR_DOWN;
               end else if (dy > 0) begin
                  st_direction   = (dx > 0) ? tjd_pkg::DIR_RIGHT_UP : tjd_pkg::DIR_LEFT_UP;
                  st_facing_left = (dx <= 0);
               end else begin
                  st_direction   = (dx > 0) ? tjd_pkg::DIR_RIGHT_DOWN
                                            : tjd_pkg::DIR_LEFT_DOWN;
                  st_facing_left = (dx <= 0);
               end
            end
         end
         tjd_pkg::OP_END: begin
            if (st_armed) begin
               st_knob_x    = cfg_center_x;
               st_knob_y    = cfg_center_y;
               st_direction = tjd_pkg::DIR_STAY;
               st_armed     = 1'b0;
            end
         end
         default: ;
      endcase
      report.direction   = st_direction;
      report.facing_left = st_facing_left;
      report.knob_x      = st_knob_x;
      report.knob_y      = st_knob_y;
      report.tracking    = st_armed;
      directions_seen[st_direction] = 1'b1;
      pending_reports.push_back(report);
   endfunction

   // Offer one request after a random gap; hold it until taken, then drop valid.
   // Waits a further edge past the handshake so the next request never lands in the same step.
   task automatic send_request(input logic [tjd_pkg::OP_BITS-1:0] op,
                               input logic [COORD_BITS-1:0] tx,
                               input logic [COORD_BITS-1:0] ty);
      int gap;
      gap = idle_enable ? $urandom_range(0, 8) : 0;
      repeat (gap) @(posedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.touch_x <= tx;
      req_ch.touch_y <= ty;
      do @(posedge clock); while (!req_ch.ready);
      predict_event(op, tx, ty);
      requests_sent++;
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_register(input logic [tjd_pkg::CSR_INDEX_BITS-1:0] index,
                                 input int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value[CSR_DATA_BITS-1:0];
      do @(posedge clock); while (!csr_ch.ready);
      case (index)
         tjd_pkg::CSR_CENTER_X:    cfg_center_x = value[COORD_BITS-1:0];
         tjd_pkg::CSR_CENTER_Y:    cfg_center_y = value[COORD_BITS-1:0];
         tjd_pkg::CSR_RADIUS:      cfg_radius   = value[tjd_pkg::RAD_BITS-1:0];
         tjd_pkg::CSR_HALF_WIDTH:  cfg_half_w   = value[tjd_pkg::HALF_BITS-1:0];
         tjd_pkg::CSR_HALF_HEIGHT: cfg_half_h   = value[tjd_pkg::HALF_BITS-1:0];
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // Reprogram every register, only once the block has gone quiet.
   task automatic program_registers(input int cx, input int cy, input int rad,
                                    input int half_w, input int half_h);
      wait_drained();
      repeat (4) @(posedge clock);
      write_register(tjd_pkg::CSR_CENTER_X, cx);
      write_register(tjd_pkg::CSR_CENTER_Y, cy);
      write_register(tjd_pkg::CSR_RADIUS, rad);
      write_register(tjd_pkg::CSR_HALF_WIDTH, half_w);
      write_register(tjd_pkg::CSR_HALF_HEIGHT, half_h);
      settings_used++;
   endtask

   // Response side: random stall per response, or one long hold when a test asks for it.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_enable ? $urandom_range(0, 8) : 0;
         if (response_hold > 0) begin
            stall = response_hold;
            response_hold = 0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Compare every accepted response with the oldest queued report.
   always @(posedge clock) begin
      joystick_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, actual dir %0d",
                     $time, rsp_ch.direction);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("direction", int'(want.direction), int'(rsp_ch.direction));
            check_field("facing_left", int'(want.facing_left), int'(rsp_ch.facing_left));
            check_field("knob_x", int'(want.knob_x), int'(rsp_ch.knob_x));
            check_field("knob_y", int'(want.knob_y), int'(rsp_ch.knob_y));
            check_field("tracking", int'(want.tracking), int'(rsp_ch.tracking));
            responses_checked++;
         end
      end
   end

   // Reset values: ignored events while idle, a box miss, an inclusive box hit,
   // a centre touch, a short move and a far diagonal that clamps.
   task automatic test_default_registers();
      send_request(tjd_pkg::OP_MOVE, 50, 50);
      send_request(tjd_pkg::OP_END, 0, 0);
      send_request(OP_UNUSED, SCREEN_MAX, SCREEN_MAX);
      send_request(tjd_pkg::OP_BEGIN, 33, 0);
      send_request(tjd_pkg::OP_BEGIN, 32, 32);
      send_request(tjd_pkg::OP_MOVE, 0, 0);
      send_request(tjd_pkg::OP_MOVE, 40, 0);
      send_request(tjd_pkg::OP_MOVE, SCREEN_MAX, SCREEN_MAX);
      send_request(tjd_pkg::OP_END, 0, 0);
   endtask

   // Largest radius and box: walk all eight sectors, the straight-left case and the centre.
   task automatic test_eight_directions();
      program_registers(2048, 2048, RADIUS_MAX, HALF_MAX, HALF_MAX);
      send_request(tjd_pkg::OP_BEGIN, 2048, 2048);
      send_request(tjd_pkg::OP_MOVE, 2148, 2048);
      send_request(tjd_pkg::OP_MOVE, 2148, 2148);
      send_request(tjd_pkg::OP_MOVE, 2048, 2148);   // up after right-up: still facing right
      send_request(tjd_pkg::OP_MOVE, 1948, 2148);
      send_request(tjd_pkg::OP_MOVE, 1948, 2048);   // straight left of the centre
      send_request(tjd_pkg::OP_MOVE, 1948, 1948);
      send_request(tjd_pkg::OP_MOVE, 2048, 1948);   // down after left-down: still facing left
      send_request(tjd_pkg::OP_MOVE, 2148, 1948);
      send_request(tjd_pkg::OP_MOVE, 2048, 2048);
      send_request(tjd_pkg::OP_MOVE, 0, SCREEN_MAX);
      send_request(tjd_pkg::OP_END, 0, 0);
   endtask

   // Zero radius pins the knob to the centre; a zero box only arms on the exact centre.
   task automatic test_zero_radius_and_box();
      program_registers(COORD_MAX, 0, 0, 0, 0);
      send_request(tjd_pkg::OP_BEGIN, SCREEN_MAX - 1'b1, 0);
      send_request(tjd_pkg::OP_BEGIN, SCREEN_MAX, 0);
      send_request(tjd_pkg::OP_MOVE, 0, SCREEN_MAX);
      send_request(tjd_pkg::OP_MOVE, SCREEN_MAX, 0);
      send_request(tjd_pkg::OP_END, 0, 0);
   endtask

   // Hold off responses long enough that the block stalls its request side,
   // then pause the sender until everything has drained.
   task automatic test_response_backpressure();
      program_registers(1000, 1000, 100, 50, 50);
      response_hold = 300;
      send_request(tjd_pkg::OP_BEGIN, 1010, 990);
      repeat (10) send_request(tjd_pkg::OP_MOVE, coord_near(1000, 220), coord_near(1000, 220));
      send_request(tjd_pkg::OP_END, 0, 0);
      wait_drained();
      send_request(tjd_pkg::OP_BEGIN, 1000, 1000);
      send_request(tjd_pkg::OP_MOVE, 1200, 1000);
      send_request(tjd_pkg::OP_END, SCREEN_MAX, SCREEN_MAX);
   endtask

   // Mostly complete gestures (begin in the box, moves, end) with random content;
   // the rest is raw noise on every event code and coordinate.
   task automatic test_random_gestures(input int item_budget, input bit with_idling);
      int sent;
      int moves;
      int span;
      int rad;
      int raw_op;
      idle_enable = with_idling;
      case ($urandom_range(0, 2))
         0: rad = $urandom_range(0, 64);
         default: rad = pick_extreme(RADIUS_MAX);
      endcase
      program_registers(pick_extreme(COORD_MAX), pick_extreme(COORD_MAX), rad,
                        pick_extreme(HALF_MAX), pick_extreme(HALF_MAX));
      span = 2 * rad + 16;
      sent = 0;
      while (sent < item_budget) begin
         if ($urandom_range(0, 99) < 85) begin
            send_request(tjd_pkg::OP_BEGIN, coord_near(int'(cfg_center_x), int'(cfg_half_w)),
                         coord_near(int'(cfg_center_y), int'(cfg_half_h)));
            moves = $urandom_range(1, 8);
            repeat (moves) begin
               case ($urandom_range(0, 15))
                  0: send_request(tjd_pkg::OP_MOVE, cfg_center_x, cfg_center_y);
                  1, 2, 3, 4: send_request(tjd_pkg::OP_MOVE, any_coord(), any_coord());
                  default: send_request(tjd_pkg::OP_MOVE, coord_near(int'(cfg_center_x), span),
                                        coord_near(int'(cfg_center_y), span));
               endcase
            end
            // leave some gestures open so the next begin finds tracking already set
            if ($urandom_range(0, 9) != 0)
               send_request(tjd_pkg::OP_END, any_coord(), any_coord());
            sent += moves + 2;
         end else begin
            raw_op = $urandom_range(0, 3);
            send_request(raw_op[tjd_pkg::OP_BITS-1:0], any_coord(), any_coord());
            sent++;
         end
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      // drive every input known from time zero, then hold reset and release it
      req_ch.valid   <= 1'b0;
      req_ch.op      <= tjd_pkg::OP_BEGIN;
      req_ch.touch_x <= '0;
      req_ch.touch_y <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= tjd_pkg::CSR_CENTER_X;
      csr_ch.data    <= '0;
      reset          <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_registers();
      test_eight_directions();
      test_zero_radius_and_box();
      test_response_backpressure();
      // one phase runs with neither side idling
      for (int phase = 0; phase < 6; phase++)
         test_random_gestures(170, phase != 2);

      // drain, then leave room for any stray response
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d touch events, %0d responses compared, %0d clamped moves.",
               requests_sent, responses_checked, clamped_moves);
      $display("Direction codes reported (right-down..stay): %b over %0d register settings.",
               directions_seen, settings_used);
      if (error_count == 0) begin
         $display("touch_joystick_direction_decoder_top test passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("touch_joystick_direction_decoder_top test failed");
      end
      $finish;
   end

endmodule
